// File: rtl/status_led_blink_controller_macros.svh
// Assertion macros shared by the status LED blink controller modules.
`ifndef STATUS_LED_BLINK_CONTROLLER_MACROS_SVH
`define STATUS_LED_BLINK_CONTROLLER_MACROS_SVH

// Checked on every rising edge outside reset.
`define SLBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define SLBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/slbc_pkg.sv
// Types, constants and the microprogram of the status LED blink controller.
`timescale 1ns / 1ps
`default_nettype none

package slbc_pkg;

  localparam int NUM_LEDS  = 10;
  localparam int LED_W     = 4;
  localparam int IDX_W     = $clog2(NUM_LEDS);
  localparam int OP_W      = 3;
  localparam int MODE_W    = 2;
  localparam int LINK_W    = 2;
  localparam int PCT_W     = 7;
  localparam int PER_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam int UPC_W     = 6;
  localparam int NUM_COND  = 16;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET     = 3'd1;
  localparam logic [OP_W-1:0] OP_NETWORK = 3'd2;
  localparam logic [OP_W-1:0] OP_BATTERY = 3'd3;
  localparam logic [OP_W-1:0] OP_WIFI    = 3'd4;
  localparam logic [OP_W-1:0] OP_ALL_OFF = 3'd5;

  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BAT_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH     = 2'd3;

  localparam logic [LED_W-1:0] LTE_R  = 4'd0;
  localparam logic [LED_W-1:0] LTE_G  = 4'd1;
  localparam logic [LED_W-1:0] LTE_B  = 4'd2;
  localparam logic [LED_W-1:0] NR_R   = 4'd3;
  localparam logic [LED_W-1:0] NR_G   = 4'd4;
  localparam logic [LED_W-1:0] NR_B   = 4'd5;
  localparam logic [LED_W-1:0] BAT_R  = 4'd6;
  localparam logic [LED_W-1:0] BAT_G  = 4'd7;
  localparam logic [LED_W-1:0] WIFI_R = 4'd8;
  localparam logic [LED_W-1:0] WIFI_G = 4'd9;

  typedef enum logic [1:0] {K_NOP, K_PREP, K_SET, K_SCAN} kind_e;
  typedef enum logic [2:0] {LS_CONST, LS_CNT, LS_IDX, LS_BASE, LS_OTHER} lsel_e;
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NET_UNK, C_UNK_SHOWN, C_NET_SAME, C_LINK_UP,
    C_NO_BAT, C_CHARGING, C_LOW, C_FULL, C_WIFI_SAME, C_WIFI_RUN
  } cond_e;
  typedef enum logic [1:0] {FX_NONE, FX_NET_KNOWN, FX_NET_UNK, FX_WIFI} fx_e;

  typedef struct packed {
    kind_e             kind;
    lsel_e             lsel;
    logic [LED_W-1:0]  arg;
    logic              in_mode;
    logic [MODE_W-1:0] mode;
    cond_e             cond;
    logic [UPC_W-1:0]  target;
    logic              loop;
    logic              fin;
    fx_e               fx;
  } ucw_t;

  typedef struct packed {
    logic busy;
    logic step;
    logic flush;
  } seq_t;

  typedef struct packed {
    logic             valid;
    logic [LED_W-1:0] led;
    logic             level;
  } emit_t;

  localparam logic [UPC_W-1:0] A_DONE    = 6'd0;
  localparam logic [UPC_W-1:0] A_TICK    = 6'd1;
  localparam logic [UPC_W-1:0] A_SET     = 6'd3;
  localparam logic [UPC_W-1:0] A_NET     = 6'd4;
  localparam logic [UPC_W-1:0] A_NET_ON  = 6'd11;
  localparam logic [UPC_W-1:0] A_NET_END = 6'd13;
  localparam logic [UPC_W-1:0] A_NET_UNK = 6'd14;
  localparam logic [UPC_W-1:0] A_BAT     = 6'd21;
  localparam logic [UPC_W-1:0] A_BAT_OK  = 6'd24;
  localparam logic [UPC_W-1:0] A_BAT_LOW = 6'd26;
  localparam logic [UPC_W-1:0] A_BAT_CHG = 6'd28;
  localparam logic [UPC_W-1:0] A_BAT_CL  = 6'd32;
  localparam logic [UPC_W-1:0] A_WIFI    = 6'd34;
  localparam logic [UPC_W-1:0] A_WIFI_ON = 6'd37;
  localparam logic [UPC_W-1:0] A_ALL_OFF = 6'd38;
  localparam logic [UPC_W-1:0] UCODE_LEN = 6'd39;

  function automatic ucw_t u_nop(cond_e c, logic [UPC_W-1:0] t, fx_e f, logic fin);
    ucw_t w;
    w        = '0;
    w.kind   = K_NOP;
    w.lsel   = LS_CONST;
    w.cond   = c;
    w.target = t;
    w.fx     = f;
    w.fin    = fin;
    return w;
  endfunction

  function automatic ucw_t u_set(lsel_e s, logic [LED_W-1:0] a, logic [MODE_W-1:0] m,
                                 cond_e c, logic [UPC_W-1:0] t, logic fin);
    ucw_t w;
    w        = u_nop(c, t, FX_NONE, fin);
    w.kind   = K_SET;
    w.lsel   = s;
    w.arg    = a;
    w.mode   = m;
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] entry(logic [OP_W-1:0] op);
    logic [UPC_W-1:0] a;
    unique case (op)
      OP_TICK:    a = A_TICK;
      OP_SET:     a = A_SET;
      OP_NETWORK: a = A_NET;
      OP_BATTERY: a = A_BAT;
      OP_WIFI:    a = A_WIFI;
      OP_ALL_OFF: a = A_ALL_OFF;
      default:    a = A_DONE;
    endcase
    return a;
  endfunction

  function automatic ucw_t ucode(logic [UPC_W-1:0] pc);
    ucw_t w;
    w = u_nop(C_NEVER, A_DONE, FX_NONE, 1'b1);
    unique case (pc)
      6'd1: begin
        w.kind = K_PREP;
        w.fin  = 1'b0;
      end
      6'd2: begin
        w.kind = K_SCAN;
        w.lsel = LS_CNT;
        w.loop = 1'b1;
      end
      6'd3: begin
        w         = u_set(LS_IDX, '0, MODE_OFF, C_NEVER, A_DONE, 1'b1);
        w.in_mode = 1'b1;
      end
      6'd4:  w = u_nop(C_NET_UNK, A_NET_UNK, FX_NONE, 1'b0);
      6'd5:  w = u_nop(C_NET_SAME, A_DONE, FX_NET_KNOWN, 1'b0);
      6'd6:  w = u_set(LS_OTHER, 4'd0, MODE_OFF, C_NEVER, A_DONE, 1'b0);
      6'd7:  w = u_set(LS_OTHER, 4'd1, MODE_OFF, C_NEVER, A_DONE, 1'b0);
      6'd8:  w = u_set(LS_OTHER, 4'd2, MODE_OFF, C_LINK_UP, A_NET_ON, 1'b0);
      6'd9:  w = u_set(LS_BASE, 4'd0, MODE_SLOW, C_NEVER, A_DONE, 1'b0);
      6'd10: w = u_set(LS_BASE, 4'd1, MODE_OFF, C_ALWAYS, A_NET_END, 1'b0);
      6'd11: w = u_set(LS_BASE, 4'd0, MODE_OFF, C_NEVER, A_DONE, 1'b0);
      6'd12: w = u_set(LS_BASE, 4'd1, MODE_ON, C_NEVER, A_DONE, 1'b0);
      6'd13: w = u_set(LS_BASE, 4'd2, MODE_OFF, C_NEVER, A_DONE, 1'b1);
      6'd14: w = u_nop(C_UNK_SHOWN, A_DONE, FX_NET_UNK, 1'b0);
      6'd15: w = u_set(LS_CONST, LTE_R, MODE_SLOW, C_NEVER, A_DONE, 1'b0);
      6'd16: w = u_set(LS_CONST, LTE_G, MODE_OFF, C_NEVER, A_DONE, 1'b0);
      6'd17: w = u_set(LS_CONST, LTE_B, MODE_OFF, C_NEVER, A_DONE, 1'b0);
      6'd18: w = u_set(LS_CONST, NR_R, MODE_SLOW, C_NEVER, A_DONE, 1'b0);
      6'd19: w = u_set(LS_CONST, NR_G, MODE_OFF, C_NEVER, A_DONE, 1'b0);
      6'd20: w = u_set(LS_CONST, NR_B, MODE_OFF, C_NEVER, A_DONE, 1'b1);
      6'd21: w = u_nop(C_NO_BAT, A_DONE, FX_NONE, 1'b0);
      6'd22: w = u_nop(C_CHARGING, A_BAT_CHG, FX_NONE, 1'b0);
      6'd23: w = u_nop(C_LOW, A_BAT_LOW, FX_NONE, 1'b0);
      6'd24: w = u_set(LS_CONST, BAT_R, MODE_OFF, C_NEVER, A_DONE, 1'b0);
      6'd25: w = u_set(LS_CONST, BAT_G, MODE_ON, C_NEVER, A_DONE, 1'b1);
      6'd26: w = u_set(LS_CONST, BAT_R, MODE_ON, C_NEVER, A_DONE, 1'b0);
      6'd27: w = u_set(LS_CONST, BAT_G, MODE_OFF, C_NEVER, A_DONE, 1'b1);
      6'd28: w = u_nop(C_LOW, A_BAT_CL, FX_NONE, 1'b0);
      6'd29: w = u_nop(C_FULL, A_BAT_OK, FX_NONE, 1'b0);
      6'd30: w = u_set(LS_CONST, BAT_R, MODE_OFF, C_NEVER, A_DONE, 1'b0);
      6'd31: w = u_set(LS_CONST, BAT_G, MODE_SLOW, C_NEVER, A_DONE, 1'b1);
      6'd32: w = u_set(LS_CONST, BAT_R, MODE_SLOW, C_NEVER, A_DONE, 1'b0);
      6'd33: w = u_set(LS_CONST, BAT_G, MODE_OFF, C_NEVER, A_DONE, 1'b1);
      6'd34: w = u_nop(C_WIFI_SAME, A_DONE, FX_WIFI, 1'b0);
      6'd35: w = u_set(LS_CONST, WIFI_R, MODE_OFF, C_WIFI_RUN, A_WIFI_ON, 1'b0);
      6'd36: w = u_set(LS_CONST, WIFI_G, MODE_SLOW, C_NEVER, A_DONE, 1'b1);
      6'd37: w = u_set(LS_CONST, WIFI_G, MODE_ON, C_NEVER, A_DONE, 1'b1);
      6'd38: begin
        w      = u_set(LS_CNT, '0, MODE_OFF, C_NEVER, A_DONE, 1'b1);
        w.loop = 1'b1;
      end
      default: w = u_nop(C_NEVER, A_DONE, FX_NONE, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/slbc_useq.sv
// Microprogram sequencer: step counter, loop counter and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module slbc_useq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [slbc_pkg::OP_W-1:0]     op_i,
  input  logic [slbc_pkg::NUM_COND-1:0] cond_i,
  input  logic                          out_free_i,
  output slbc_pkg::ucw_t                ctrl_o,
  output logic [slbc_pkg::IDX_W-1:0]    cnt_o,
  output slbc_pkg::seq_t                seq_o
);
  import slbc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [UPC_W-1:0] pc_q, pc_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  ucw_t             ctrl;

  assign ctrl = ucode(pc_q);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          pc_d    = entry(op_i);
          cnt_d   = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (out_free_i) begin
          if (cond_i[ctrl.cond]) begin
            pc_d = ctrl.target;
          end else if (ctrl.loop && (cnt_q != IDX_W'(NUM_LEDS - 1))) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            cnt_d = '0;
            if (ctrl.fin) begin
              state_d = S_FLUSH;
            end else begin
              pc_d = pc_q + 1'b1;
            end
          end
        end
      end
      S_FLUSH: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= A_DONE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
    end
  end

  assign ctrl_o      = ctrl;
  assign cnt_o       = cnt_q;
  assign seq_o.busy  = (state_q != S_IDLE);
  assign seq_o.step  = (state_q == S_RUN) && out_free_i;
  assign seq_o.flush = (state_q == S_FLUSH) && out_free_i;

`include "status_led_blink_controller_macros.svh"

  `SLBC_ASSERT(a_pc_in_rom, (state_q == S_RUN) |-> (pc_q < UCODE_LEN), "step counter left the program")
  `SLBC_ASSERT(a_cnt_idle, !((state_q == S_RUN) && ctrl.loop) |-> (cnt_q == '0), "loop counter not cleared")
  `SLBC_ASSERT(a_flush_once, (state_q == S_FLUSH) && out_free_i |=> (state_q == S_IDLE), "flush did not end the transaction")

endmodule

`default_nettype wire

// File: rtl/slbc_led_bank.sv
// LED mode and level store with blink phase, refresh counter and write generation.
`timescale 1ns / 1ps
`default_nettype none

module slbc_led_bank (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slbc_pkg::ucw_t                ctrl_i,
  input  logic                          step_i,
  input  logic [slbc_pkg::IDX_W-1:0]    cnt_i,
  input  logic [slbc_pkg::LED_W-1:0]    in_idx_i,
  input  logic [slbc_pkg::MODE_W-1:0]   in_mode_i,
  input  logic                          is_5g_i,
  input  logic [slbc_pkg::PER_W-1:0]    refresh_period_i,
  output slbc_pkg::emit_t               emit_o
);
  import slbc_pkg::*;

  logic [MODE_W-1:0]   modes_q [NUM_LEDS];
  logic [NUM_LEDS-1:0] levels_q;
  logic                phase_q;
  logic [PER_W-1:0]    refresh_q;
  logic                force_q;

  logic [LED_W-1:0]  led, base, other;
  logic              led_ok;
  logic [IDX_W-1:0]  widx;
  logic [MODE_W-1:0] mode_w, cur_mode;
  logic              want;
  logic [PER_W-1:0]  period;
  logic [PER_W:0]    next_cnt;
  logic              due;

  assign base  = is_5g_i ? NR_R : LTE_R;
  assign other = is_5g_i ? LTE_R : NR_R;

  always_comb begin
    unique case (ctrl_i.lsel)
      LS_CONST: led = ctrl_i.arg;
      LS_CNT:   led = LED_W'(cnt_i);
      LS_IDX:   led = in_idx_i;
      LS_BASE:  led = base + ctrl_i.arg;
      LS_OTHER: led = other + ctrl_i.arg;
      default:  led = ctrl_i.arg;
    endcase
  end

  assign led_ok   = {1'b0, led} < (LED_W + 1)'(NUM_LEDS);
  assign widx     = led[IDX_W-1:0];
  assign mode_w   = ctrl_i.in_mode ? in_mode_i : ctrl_i.mode;
  assign cur_mode = modes_q[cnt_i];
  assign want     = cur_mode[1] ? ~phase_q : cur_mode[0];

  assign period   = (refresh_period_i == '0) ? PER_W'(1) : refresh_period_i;
  assign next_cnt = {1'b0, refresh_q} + 1'b1;
  assign due      = next_cnt >= {1'b0, period};

  always_comb begin
    emit_o = '0;
    unique case (ctrl_i.kind)
      K_SET: begin
        emit_o.valid = step_i && led_ok && !mode_w[1];
        emit_o.led   = led;
        emit_o.level = mode_w[0];
      end
      K_SCAN: begin
        emit_o.valid = step_i && (force_q || (levels_q[cnt_i] != want));
        emit_o.led   = LED_W'(cnt_i);
        emit_o.level = want;
      end
      default: emit_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        modes_q[i] <= MODE_OFF;
      end
      levels_q  <= '0;
      phase_q   <= 1'b0;
      refresh_q <= '0;
      force_q   <= 1'b0;
    end else if (step_i) begin
      unique case (ctrl_i.kind)
        K_PREP: begin
          phase_q   <= ~phase_q;
          force_q   <= due;
          refresh_q <= due ? '0 : next_cnt[PER_W-1:0];
        end
        K_SET: begin
          if (led_ok) begin
            modes_q[widx] <= mode_w;
            if (!mode_w[1]) begin
              levels_q[widx] <= mode_w[0];
            end
          end
        end
        K_SCAN: levels_q[cnt_i] <= want;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/status_led_blink_controller.sv
// Top level of the status LED blink controller.
// Usage: one input transaction carries an operation (tick, set mode, network,
// battery or wifi status, all off) with its fields. The block answers with zero
// to ten output transactions, one per LED write, and marks the final one with
// last_o. Configuration registers are written through cfg_we_i, cfg_index_i
// and cfg_wdata_i; the user must write them only while the block is idle, since
// the block does not enforce this. Each operation runs as a short program from a
// control table, one step per cycle while the output register is free. A tick
// takes one preparation step, one step per LED and a final step.
// Writes leave through a one-deep hold register and an output register; a write
// moves on only when the next write is generated or the program finishes.
// in_ready_o stays high whenever no operation is in progress, also while a
// result still waits in the output register. When the receiver stalls, the
// program stops at the next step until the output register frees up.
// Reset clears all modes and levels, the blink phase, the refresh counter and
// the status history, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module status_led_blink_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [slbc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [slbc_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [slbc_pkg::OP_W-1:0]      op_i,
  input  logic [slbc_pkg::LED_W-1:0]     led_index_i,
  input  logic [slbc_pkg::MODE_W-1:0]    mode_i,
  input  logic [slbc_pkg::LINK_W-1:0]    link_state_i,
  input  logic                           is_5g_i,
  input  logic [slbc_pkg::PCT_W-1:0]     capacity_i,
  input  logic                           charging_i,
  input  logic                           wifi_running_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [slbc_pkg::LED_W-1:0]     led_out_o,
  output logic                           level_o,
  output logic                           last_o
);
  import slbc_pkg::*;

  logic             bat_present_q;
  logic [PCT_W-1:0] low_level_q, full_level_q;
  logic [PER_W-1:0] refresh_period_q;

  logic [LED_W-1:0]  idx_q;
  logic [MODE_W-1:0] mode_q;
  logic [LINK_W-1:0] link_q;
  logic              g5_q, chg_q, run_q;
  logic [PCT_W-1:0]  cap_q;

  logic net_seen_q, net_conn_q, net_5g_q, net_unk_q, wifi_seen_q, wifi_last_q;

  logic                out_valid_q, out_valid_d, out_level_q, out_last_q;
  logic [LED_W-1:0]    out_led_q;
  logic                hold_v_q, hold_v_d, hold_level_q;
  logic [LED_W-1:0]    hold_led_q;
  logic                load_out, last_d;

  logic                accept, out_free, net_same, wifi_same;
  logic [NUM_COND-1:0] cond_vec;
  ucw_t                ctrl;
  logic [IDX_W-1:0]    cnt;
  seq_t                seq;
  emit_t               emit;

  assign in_ready_o = !seq.busy;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bat_present_q    <= 1'b1;
      low_level_q      <= PCT_W'(30);
      full_level_q     <= PCT_W'(100);
      refresh_period_q <= PER_W'(6);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BAT_PRESENT: bat_present_q    <= cfg_wdata_i[0];
        REG_LOW_LEVEL:   low_level_q      <= cfg_wdata_i;
        REG_FULL_LEVEL:  full_level_q     <= cfg_wdata_i;
        REG_REFRESH:     refresh_period_q <= cfg_wdata_i[PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q  <= led_index_i;
      mode_q <= mode_i;
      link_q <= link_state_i;
      g5_q   <= is_5g_i;
      cap_q  <= capacity_i;
      chg_q  <= charging_i;
      run_q  <= wifi_running_i;
    end
  end

  assign net_same  = net_seen_q && (net_conn_q == link_q[0]) && (net_5g_q == g5_q);
  assign wifi_same = wifi_seen_q && (wifi_last_q == run_q);

  always_comb begin
    cond_vec              = '0;
    cond_vec[C_ALWAYS]    = 1'b1;
    cond_vec[C_NET_UNK]   = link_q[1];
    cond_vec[C_UNK_SHOWN] = net_unk_q;
    cond_vec[C_NET_SAME]  = net_same;
    cond_vec[C_LINK_UP]   = link_q[0];
    cond_vec[C_NO_BAT]    = !bat_present_q;
    cond_vec[C_CHARGING]  = chg_q;
    cond_vec[C_LOW]       = cap_q < low_level_q;
    cond_vec[C_FULL]      = cap_q >= full_level_q;
    cond_vec[C_WIFI_SAME] = wifi_same;
    cond_vec[C_WIFI_RUN]  = run_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_seen_q  <= 1'b0;
      net_conn_q  <= 1'b0;
      net_5g_q    <= 1'b0;
      net_unk_q   <= 1'b0;
      wifi_seen_q <= 1'b0;
      wifi_last_q <= 1'b0;
    end else if (seq.step) begin
      unique case (ctrl.fx)
        FX_NET_KNOWN: begin
          net_unk_q <= 1'b0;
          if (!net_same) begin
            net_seen_q <= 1'b1;
            net_conn_q <= link_q[0];
            net_5g_q   <= g5_q;
          end
        end
        FX_NET_UNK: begin
          net_unk_q  <= 1'b1;
          net_seen_q <= 1'b0;
        end
        FX_WIFI: begin
          if (!wifi_same) begin
            wifi_seen_q <= 1'b1;
            wifi_last_q <= run_q;
          end
        end
        default: ;
      endcase
    end
  end

  slbc_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .op_i       (op_i),
    .cond_i     (cond_vec),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .cnt_o      (cnt),
    .seq_o      (seq)
  );

  slbc_led_bank u_led_bank (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .step_i           (seq.step),
    .cnt_i            (cnt),
    .in_idx_i         (idx_q),
    .in_mode_i        (mode_q),
    .is_5g_i          (g5_q),
    .refresh_period_i (refresh_period_q),
    .emit_o           (emit)
  );

  // Writes wait in the hold register so the final one of a transaction can be marked.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    hold_v_d    = hold_v_q;
    load_out    = 1'b0;
    last_d      = 1'b0;
    if (emit.valid) begin
      hold_v_d = 1'b1;
      load_out = hold_v_q;
    end else if (seq.flush && hold_v_q) begin
      hold_v_d = 1'b0;
      load_out = 1'b1;
      last_d   = 1'b1;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hold_v_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      hold_v_q    <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_led_q   <= hold_led_q;
      out_level_q <= hold_level_q;
      out_last_q  <= last_d;
    end
    if (emit.valid) begin
      hold_led_q   <= emit.led;
      hold_level_q <= emit.level;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_out_o   = out_led_q;
  assign level_o     = out_level_q;
  assign last_o      = out_last_q;

`include "status_led_blink_controller_macros.svh"

  `SLBC_ASSERT(a_idle_hold_empty, in_ready_o |-> !hold_v_q, "hold register not empty while idle")
  `SLBC_ASSERT(a_led_range, out_valid_o |-> (led_out_o <= LED_W'(NUM_LEDS - 1)), "LED index out of range")
  `SLBC_ASSERT_ALWAYS(a_reset_state, !rst_ni |=> (!out_valid_o && in_ready_o), "reset state wrong")

endmodule

`default_nettype wire
